@@ design/pec_pkg.sv @@
// pec_pkg: shared opcodes, pin status codes and the lane control struct
// for the pin edge timestamp capture block. No dependencies.
`timescale 1ns / 1ps

package pec_pkg;

  // item opcodes
  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  // per-pin status codes
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_HIGH = 2'd1;
  localparam logic [1:0] ST_LOW  = 2'd2;

  // control from the input stage to the pin lanes
  typedef struct packed {
    logic do_sample;
    logic do_read;
  } lane_ctl_t;

endpackage

@@ design/pec_if.sv @@
// pec_if: valid/ready channel interfaces for the sample/read items and the
// read results. Depends on nothing but its parameters.
`timescale 1ns / 1ps

interface pec_in_if #(
  parameter int PIN_COUNT  = 24,
  parameter int TIME_WIDTH = 32,
  parameter int IDX_W      = 5
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [PIN_COUNT-1:0]  pin_levels;
  logic [TIME_WIDTH-1:0] timestamp;
  logic [IDX_W-1:0]      pin_index;

  modport source (output valid, opcode, pin_levels, timestamp, pin_index, input ready);
  modport sink   (input valid, opcode, pin_levels, timestamp, pin_index, output ready);
endinterface

interface pec_out_if #(
  parameter int TIME_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            edge_status;
  logic [TIME_WIDTH-1:0] rise_time;
  logic [TIME_WIDTH-1:0] fall_time;

  modport source (output valid, edge_status, rise_time, fall_time, input ready);
  modport sink   (input valid, edge_status, rise_time, fall_time, output ready);
endinterface

@@ design/pec_lanes.sv @@
// pec_lanes: per-pin edge detect lanes holding previous level, status and
// rise/fall timestamps, plus the clamped read mux. Uses pec_pkg.
`timescale 1ns / 1ps

module pec_lanes #(
  parameter int PIN_COUNT  = 24,
  parameter int TIME_WIDTH = 32,
  parameter int IDX_W      = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pec_pkg::lane_ctl_t    ctl,
  input  logic [PIN_COUNT-1:0]  levels,
  input  logic [TIME_WIDTH-1:0] stamp,
  input  logic [IDX_W-1:0]      idx,
  output logic [1:0]            rd_status,
  output logic [TIME_WIDTH-1:0] rd_rise,
  output logic [TIME_WIDTH-1:0] rd_fall
);

  localparam logic [IDX_W-1:0] LAST_PIN = IDX_W'(PIN_COUNT - 1);

  logic [PIN_COUNT-1:0]  prev_r, prev_nxt;
  logic [1:0]            status_r [PIN_COUNT];
  logic [1:0]            status_nxt [PIN_COUNT];
  logic [TIME_WIDTH-1:0] rise_r [PIN_COUNT];
  logic [TIME_WIDTH-1:0] rise_nxt [PIN_COUNT];
  logic [TIME_WIDTH-1:0] fall_r [PIN_COUNT];
  logic [TIME_WIDTH-1:0] fall_nxt [PIN_COUNT];
  logic [PIN_COUNT-1:0]  toggled;
  logic [IDX_W-1:0]      idx_c;

  // clamp out-of-range pin numbers to the last pin
  assign idx_c = (idx > LAST_PIN) ? LAST_PIN : idx;

  assign toggled = prev_r ^ levels;

  // lane updates: parallel edge capture on a sample, status clear on a read
  always_comb begin
    prev_nxt   = prev_r;
    status_nxt = status_r;
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    if (ctl.do_sample) begin
      prev_nxt = levels;
      for (int p = 0; p < PIN_COUNT; p++) begin
        if (toggled[p]) begin
          if (levels[p]) begin
            rise_nxt[p]   = stamp;
            status_nxt[p] = pec_pkg::ST_HIGH;
          end else begin
            fall_nxt[p]   = stamp;
            status_nxt[p] = pec_pkg::ST_LOW;
          end
        end
      end
    end
    if (ctl.do_read) begin
      status_nxt[idx_c] = pec_pkg::ST_NONE;
    end
  end

  // lane state, previous levels reset to all ones
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '1;
      for (int p = 0; p < PIN_COUNT; p++) begin
        status_r[p] <= pec_pkg::ST_NONE;
        rise_r[p]   <= '0;
        fall_r[p]   <= '0;
      end
    end else begin
      prev_r   <= prev_nxt;
      status_r <= status_nxt;
      rise_r   <= rise_nxt;
      fall_r   <= fall_nxt;
    end
  end

  // read mux sees the state before this cycle's clear
  assign rd_status = status_r[idx_c];
  assign rd_rise   = rise_r[idx_c];
  assign rd_fall   = fall_r[idx_c];

endmodule

@@ design/pec_out_reg.sv @@
// pec_out_reg: result register driving the output channel; reports when it
// can take a new result. Uses pec_if (pec_out_if).
`timescale 1ns / 1ps

module pec_out_reg #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic [1:0]            status_in,
  input  logic [TIME_WIDTH-1:0] rise_in,
  input  logic [TIME_WIDTH-1:0] fall_in,
  output logic                  free,
  pec_out_if.source             out_ch
);

  logic                  valid_r;
  logic [1:0]            status_r;
  logic [TIME_WIDTH-1:0] rise_r;
  logic [TIME_WIDTH-1:0] fall_r;

  // register is free when empty or its result transfers this cycle
  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_in;
      rise_r   <= rise_in;
      fall_r   <= fall_in;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.edge_status = status_r;
  assign out_ch.rise_time   = rise_r;
  assign out_ch.fall_time   = fall_r;

endmodule

@@ design/pin_edge_timestamp_capture.sv @@
// pin_edge_timestamp_capture: top level with the input register, pin lanes
// and result register. Uses pec_pkg, pec_if, pec_lanes, pec_out_reg.
//
//   channel   direction  payload                                     transfers
//   in_ch     sink       opcode, pin_levels, timestamp, pin_index    valid & ready
//   out_ch    source     edge_status, rise_time, fall_time           valid & ready
//
// One item per clock sustained while no read waits on a held result. An
// accepted item is held in the input register; from there it updates the pin
// lanes, and a read loads the result register, which drives out_ch.valid.
// Reset is synchronous, active low; previous levels come out all ones.
// A read waits in the input register only while a held result is not taken;
// samples never wait, since they produce no result.
`timescale 1ns / 1ps

module pin_edge_timestamp_capture #(
  parameter int PIN_COUNT  = 24,
  parameter int TIME_WIDTH = 32,
  parameter int IDX_W      = 5
) (
  input  logic      clk,
  input  logic      rst_n,
  pec_in_if.sink    in_ch,
  pec_out_if.source out_ch
);

  logic                  s1_valid_r;
  pec_pkg::op_t          s1_op_r;
  logic [PIN_COUNT-1:0]  s1_levels_r;
  logic [TIME_WIDTH-1:0] s1_time_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic                  s1_go;
  logic                  out_free;
  pec_pkg::lane_ctl_t    lane_ctl;
  logic [1:0]            rd_status;
  logic [TIME_WIDTH-1:0] rd_rise;
  logic [TIME_WIDTH-1:0] rd_fall;

  // input stage advances unless a read meets a held result
  assign s1_go = s1_valid_r && ((s1_op_r == pec_pkg::OP_SAMPLE) || out_free);
  assign in_ch.ready = !s1_valid_r || s1_go;

  assign lane_ctl.do_sample = s1_go && (s1_op_r == pec_pkg::OP_SAMPLE);
  assign lane_ctl.do_read   = s1_go && (s1_op_r == pec_pkg::OP_READ);

  // input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r     <= pec_pkg::op_t'(in_ch.opcode);
      s1_levels_r <= in_ch.pin_levels;
      s1_time_r   <= in_ch.timestamp;
      s1_idx_r    <= in_ch.pin_index;
    end
  end

  pec_lanes #(
    .PIN_COUNT  (PIN_COUNT),
    .TIME_WIDTH (TIME_WIDTH),
    .IDX_W      (IDX_W)
  ) u_lanes (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lane_ctl),
    .levels    (s1_levels_r),
    .stamp     (s1_time_r),
    .idx       (s1_idx_r),
    .rd_status (rd_status),
    .rd_rise   (rd_rise),
    .rd_fall   (rd_fall)
  );

  pec_out_reg #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (lane_ctl.do_read),
    .status_in (rd_status),
    .rise_in   (rd_rise),
    .fall_in   (rd_fall),
    .free      (out_free),
    .out_ch    (out_ch)
  );

endmodule

@@ tb/sv/pec_capture_monitor.sv @@
// pec_capture_monitor: watches the item and result channels of the pin edge
// capture block, predicts each read result and compares it field by field.
// Depends on pec_pkg and the pec_in_if / pec_out_if interfaces.
`timescale 1ns / 1ps

module pec_capture_monitor (
  input  logic clk,
  input  logic rst_n,
  pec_in_if    in_ch,
  pec_out_if   out_ch,
  output int   mismatches,
  output int   outstanding
);

  localparam int PINS = 24;
  localparam int TW   = 32;

  typedef struct packed {
    logic [1:0]    status;
    logic [TW-1:0] rise;
    logic [TW-1:0] fall;
  } pin_report_t;

  // predicted pin state
  logic [PINS-1:0] seen_levels;
  logic [1:0]      status_mem [PINS];
  logic [TW-1:0]   rise_mem   [PINS];
  logic [TW-1:0]   fall_mem   [PINS];
  pin_report_t     pending_reports [$];

  // compare the new levels with the last ones and stamp every changed pin
  task automatic record_edges(input logic [PINS-1:0] lv, input logic [TW-1:0] ts);
    logic [PINS-1:0] changed;
    changed = lv ^ seen_levels;
    for (int p = 0; p < PINS; p++) begin
      if (changed[p]) begin
        if (lv[p]) begin
          rise_mem[p]   = ts;
          status_mem[p] = pec_pkg::ST_HIGH;
        end else begin
          fall_mem[p]   = ts;
          status_mem[p] = pec_pkg::ST_LOW;
        end
      end
    end
    seen_levels = lv;
  endtask

  // report one pin, index clamped to the last pin, then clear its status
  task automatic read_and_clear(input logic [4:0] idx, output pin_report_t rpt);
    int p;
    p = (int'(idx) > PINS - 1) ? PINS - 1 : int'(idx);
    rpt.status    = status_mem[p];
    rpt.rise      = rise_mem[p];
    rpt.fall      = fall_mem[p];
    status_mem[p] = pec_pkg::ST_NONE;
  endtask

  always @(posedge clk) begin
    pin_report_t want;
    pin_report_t got;
    if (!rst_n) begin
      mismatches = 0;
      seen_levels = '1;
      for (int p = 0; p < PINS; p++) begin
        status_mem[p] = pec_pkg::ST_NONE;
        rise_mem[p]   = '0;
        fall_mem[p]   = '0;
      end
      pending_reports.delete();
    end else begin
      // result transfer: check against the oldest expected report
      if (out_ch.valid && out_ch.ready) begin
        if (pending_reports.size() == 0) begin
          $error("result with no read pending: edge_status %0d rise_time %0h fall_time %0h",
                 out_ch.edge_status, out_ch.rise_time, out_ch.fall_time);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          if (out_ch.edge_status !== want.status) begin
            $error("edge_status mismatch: expected %0d, actual %0d",
                   want.status, out_ch.edge_status);
            mismatches++;
          end
          if (out_ch.rise_time !== want.rise) begin
            $error("rise_time mismatch: expected %0h, actual %0h",
                   want.rise, out_ch.rise_time);
            mismatches++;
          end
          if (out_ch.fall_time !== want.fall) begin
            $error("fall_time mismatch: expected %0h, actual %0h",
                   want.fall, out_ch.fall_time);
            mismatches++;
          end
        end
      end
      // item transfer: update the prediction
      if (in_ch.valid && in_ch.ready) begin
        if (pec_pkg::op_t'(in_ch.opcode) == pec_pkg::OP_READ) begin
          read_and_clear(in_ch.pin_index, got);
          pending_reports.push_back(got);
        end else begin
          record_edges(in_ch.pin_levels, in_ch.timestamp);
        end
      end
    end
    outstanding <= pending_reports.size();
  end

endmodule

@@ tb/sv/tb_pin_edge_timestamp_capture.sv @@
// tb_pin_edge_timestamp_capture: drives sample and read items with random
// gaps and result stalls, and gives the verdict from pec_capture_monitor.
// Depends on pec_pkg, pec_if, the block and pec_capture_monitor.
`timescale 1ns / 1ps

module tb_pin_edge_timestamp_capture;

  localparam int PINS         = 24;
  localparam int TW           = 32;
  localparam int IDX_W        = 5;
  localparam int RANDOM_ITEMS = 1530;
  localparam int IDLE_LIMIT   = 2000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bit              calm = 1'b0;
  logic [PINS-1:0] drive_levels = '1;
  int              mismatches;
  int              outstanding;
  int              idle_cycles = 0;

  pec_in_if #(.PIN_COUNT(PINS), .TIME_WIDTH(TW), .IDX_W(IDX_W)) in_ch ();
  pec_out_if #(.TIME_WIDTH(TW)) out_ch ();

  pin_edge_timestamp_capture #(.PIN_COUNT(PINS), .TIME_WIDTH(TW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pec_capture_monitor capture_mon (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  // idle cycles before the next item or result, none during calm stretches
  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 19));
  endfunction

  // one item transfer; valid stays high into the next item when no gap
  task automatic send_item(input pec_pkg::op_t op, input logic [PINS-1:0] lv,
                           input logic [TW-1:0] ts, input logic [IDX_W-1:0] idx);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.opcode     <= op;
    in_ch.pin_levels <= lv;
    in_ch.timestamp  <= ts;
    in_ch.pin_index  <= idx;
    in_ch.valid      <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // sample with a don't-care pin index
  task automatic sample_pins(input logic [PINS-1:0] lv, input logic [TW-1:0] ts);
    logic [31:0] junk;
    junk = $urandom;
    send_item(pec_pkg::OP_SAMPLE, lv, ts, junk[IDX_W-1:0]);
    drive_levels = lv;
  endtask

  // read with don't-care levels and timestamp
  task automatic read_pin(input logic [IDX_W-1:0] idx);
    logic [31:0] junk_lv;
    logic [31:0] junk_ts;
    junk_lv = $urandom;
    junk_ts = $urandom;
    send_item(pec_pkg::OP_READ, junk_lv[PINS-1:0], junk_ts, idx);
  endtask

  // result side: random stalls between result transfers
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("pin_edge_timestamp_capture test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [PINS-1:0] lv;
    logic [PINS-1:0] flips;
    logic [TW-1:0]   ts;
    logic [TW-1:0]   clock_now;
    logic [31:0]     r;
    int              mode;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = pec_pkg::OP_SAMPLE;
    in_ch.pin_levels = '0;
    in_ch.timestamp  = '0;
    in_ch.pin_index  = '0;
    clock_now        = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // first sample after reset: every low pin is a falling edge
    sample_pins('0, 32'h0000_0001);
    read_pin(5'd0);
    read_pin(5'd23);
    // out of range index reads the last pin, status already cleared
    read_pin(5'd31);
    sample_pins('1, 32'hFFFF_FFFF);
    read_pin(5'd0);
    read_pin(5'd0);
    // several edges before a read
    sample_pins(24'hAAAAAA, 32'h8000_0000);
    sample_pins(24'h555555, 32'h7FFF_FFFF);
    read_pin(5'd1);
    read_pin(5'd2);
    read_pin(5'd24);
    // unchanged levels leave status alone
    sample_pins(24'h555555, 32'h1234_5678);
    read_pin(5'd5);
    read_pin(5'd6);
    sample_pins('0, 32'h0000_0000);
    read_pin(5'd17);
    read_pin(5'd30);
    sample_pins(24'h800001, 32'hDEAD_BEEF);
    read_pin(5'd23);
    read_pin(5'd0);

    // random part: mostly small level changes on a rising clock value
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 79) == 0) calm = ~calm;
      if ($urandom_range(0, 99) < 55) begin
        r     = $urandom;
        mode  = $urandom_range(0, 9);
        flips = '0;
        if (mode <= 3) begin
          flips[$urandom_range(0, PINS - 1)] = 1'b1;
        end else if (mode <= 6) begin
          flips = r[PINS-1:0] & PINS'($urandom);
        end
        lv = drive_levels ^ flips;
        if (mode == 8) lv = r[PINS-1:0];
        if (mode == 9) lv = r[0] ? '1 : '0;
        clock_now = clock_now + TW'($urandom_range(1, 1000));
        ts = ($urandom_range(0, 9) == 0) ? TW'($urandom) : clock_now;
        sample_pins(lv, ts);
      end else if ($urandom_range(0, 9) == 0) begin
        read_pin(IDX_W'($urandom_range(24, 31)));
      end else begin
        read_pin(IDX_W'($urandom_range(0, 23)));
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("pin_edge_timestamp_capture test passed");
    end else begin
      $display("pin_edge_timestamp_capture test failed");
    end
    $finish;
  end

endmodule
